// ===== sv/spfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spfm_pkg
// Shared widths, kind codes and types for the single precision multiplier.
// ----------------------------------------------------------------------------
package spfm_pkg;
  localparam int FracBits = 23;
  localparam int ExpBits  = 8;
  localparam int WordBits = FracBits + ExpBits + 1;
  localparam int SigBits  = FracBits + 1;
  localparam int ProdBits = 2 * SigBits;

  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_QNAN   = 2'd1;
  localparam logic [1:0] KIND_ZERO   = 2'd2;
  localparam logic [1:0] KIND_INF    = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic               sign;
    logic [ExpBits+1:0] exp_sum;
    logic [SigBits-1:0] sig_a;
    logic [SigBits-1:0] sig_b;
  } spfm_cls_t;
endpackage
`default_nettype wire

// ===== sv/spfm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spfm_front
// Classify an operand pair and register it with a skid stage.
// ----------------------------------------------------------------------------
module spfm_front import spfm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [WordBits-1:0] a,
  input  wire logic [WordBits-1:0] b,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output spfm_cls_t                out_item
);
  logic [ExpBits-1:0] ea, eb;
  logic [FracBits-1:0] fa, fb;
  logic za, zb, ia, ib;
  spfm_cls_t cls;
  spfm_cls_t skid;
  logic skid_valid;

  always_comb begin
    ea = a[WordBits-2:FracBits];
    eb = b[WordBits-2:FracBits];
    fa = a[FracBits-1:0];
    fb = b[FracBits-1:0];
    za = (ea == '0);
    zb = (eb == '0);
    ia = (ea == '1);
    ib = (eb == '1);
    cls.sign = a[WordBits-1] ^ b[WordBits-1];
    cls.exp_sum = {2'b00, ea} + {2'b00, eb};
    cls.sig_a = {1'b1, fa};
    cls.sig_b = {1'b1, fb};
    if ((ia && fa != '0) || (ib && fb != '0) || (ia && zb) || (ib && za)) begin
      cls.kind = KIND_QNAN;
    end else if (za || zb) begin
      cls.kind = KIND_ZERO;
    end else if (ia || ib) begin
      cls.kind = KIND_INF;
    end else begin
      cls.kind = KIND_NORMAL;
    end
  end

  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || in_valid;
      out_item   <= skid_valid ? skid : cls;
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid       <= cls;
      skid_valid <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== sv/spfm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spfm_back
// Multiply significands, normalize, pack, and hold the result in a skid pair.
// ----------------------------------------------------------------------------
module spfm_back import spfm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire spfm_cls_t           in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WordBits-1:0]      product,
  output logic                     overflow_flag,
  output logic                     underflow_flag
);
  localparam logic [ExpBits+1:0] Bias = (ExpBits+2)'((1 << (ExpBits - 1)) - 1);
  localparam logic [ExpBits+1:0] ExpMax = (ExpBits+2)'((1 << ExpBits) - 2);

  // stage 1: registered product
  logic               s1_valid;
  logic [1:0]         s1_kind;
  logic               s1_sign;
  logic [ExpBits+1:0] s1_exp;
  logic [ProdBits-1:0] s1_prod;
  logic s1_adv;

  // stage 2 combinational pack
  logic [ExpBits+1:0] e;
  logic [FracBits-1:0] frac;
  logic [WordBits-1:0] res;
  logic ovf, unf;

  // output register plus skid
  logic [WordBits+1:0] hold, skid;
  logic skid_valid;

  assign s1_adv = !s1_valid || !skid_valid;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
    if (s1_adv) begin
      s1_kind <= in_item.kind;
      s1_sign <= in_item.sign;
      s1_exp  <= in_item.exp_sum - Bias;
      s1_prod <= ProdBits'(in_item.sig_a) * ProdBits'(in_item.sig_b);
    end
  end

  always_comb begin
    ovf = 1'b0;
    unf = 1'b0;
    if (s1_prod[ProdBits-1]) begin
      e = s1_exp + 1'b1;
      frac = s1_prod[ProdBits-2 -: FracBits];
    end else begin
      e = s1_exp;
      frac = s1_prod[ProdBits-3 -: FracBits];
    end
    case (s1_kind)
      KIND_QNAN: res = {1'b0, {ExpBits{1'b1}}, 1'b1, {(FracBits-1){1'b0}}};
      KIND_ZERO: res = {s1_sign, {(WordBits-1){1'b0}}};
      KIND_INF:  res = {s1_sign, {ExpBits{1'b1}}, {FracBits{1'b0}}};
      default: begin
        // sign bit of the wide exponent marks a negative result
        if (e[ExpBits+1] || e == '0) begin
          unf = 1'b1;
          res = {s1_sign, {(WordBits-1){1'b0}}};
        end else if (e > ExpMax) begin
          ovf = 1'b1;
          res = {s1_sign, {ExpBits{1'b1}}, {FracBits{1'b0}}};
        end else begin
          res = {s1_sign, e[ExpBits-1:0], frac};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || s1_valid;
      hold       <= skid_valid ? skid : {res, ovf, unf};
      skid_valid <= 1'b0;
    end else if (s1_valid && !skid_valid) begin
      skid       <= {res, ovf, unf};
      skid_valid <= 1'b1;
    end
  end

  assign product        = hold[WordBits+1:2];
  assign overflow_flag  = hold[1];
  assign underflow_flag = hold[0];
endmodule
`default_nettype wire

// ===== sv/single_precision_float_multiply.sv =====
`default_nettype none
// Path: the product passes the front, product and output registers in turn,
// and out_stall can hold it in any of them.
// Throughput: unstalled, each stage takes a new item, one pair per cycle.
// Reset: rst (synchronous, active high) empties every stage; no data cleared.
// ----------------------------------------------------------------------------
// single_precision_float_multiply
// IEEE-754 single multiply with truncation, flushed subnormals and flags.
// ----------------------------------------------------------------------------
module single_precision_float_multiply import spfm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [WordBits-1:0] operand_a,
  input  wire logic [WordBits-1:0] operand_b,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WordBits-1:0]      product,
  output logic                     overflow_flag,
  output logic                     underflow_flag
);
  // classified item handed from front to back
  spfm_cls_t q_item;
  logic q_valid, q_stall;

  // front: classify and queue the item
  spfm_front u_front (
    .clk, .rst, .in_valid, .in_stall, .a(operand_a), .b(operand_b),
    .out_valid(q_valid), .out_stall(q_stall), .out_item(q_item)
  );

  // back: multiply, normalize and deliver
  spfm_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item),
    .out_valid, .out_stall, .product, .overflow_flag, .underflow_flag
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb_single_precision_float_multiply.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_precision_float_multiply
// Drives operand pairs through the multiplier with random gaps and output
// stalls, predicts each truncated product and its flags, and checks every
// product in order against the predicted one.
// ----------------------------------------------------------------------------
module tb_single_precision_float_multiply;
  import spfm_pkg::*;

  localparam int ItemCount  = 1700;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 20;

  typedef struct packed {
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
  } operand_pair_t;

  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                ovf;
    logic                unf;
  } product_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [WordBits-1:0] operand_a = '0;
  logic [WordBits-1:0] operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WordBits-1:0] product;
  logic overflow_flag;
  logic underflow_flag;

  operand_pair_t pending_pairs[$];
  product_t      expected_products[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  calm_stretch = 1'b0;  // no idling on either side while set
  bit  hold_sender = 1'b0;   // sender waits for the pipeline to drain

  single_precision_float_multiply dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .product(product), .overflow_flag(overflow_flag),
    .underflow_flag(underflow_flag)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predict the truncated product of one operand pair.
  function automatic product_t multiply_truncated(input operand_pair_t p);
    product_t r;
    logic [FracBits-1:0] fa, fb, frac;
    logic [ExpBits-1:0] ea, eb;
    logic sgn;
    logic [ProdBits-1:0] prod;
    int e;
    fa = p.a[FracBits-1:0];
    fb = p.b[FracBits-1:0];
    ea = p.a[WordBits-2:FracBits];
    eb = p.b[WordBits-2:FracBits];
    sgn = p.a[WordBits-1] ^ p.b[WordBits-1];
    r = '0;
    if ((&ea && fa != 0) || (&eb && fb != 0)) begin
      r.word = {1'b0, {ExpBits{1'b1}}, 1'b1, {(FracBits-1){1'b0}}};
    end else if ((&ea && eb == 0) || (&eb && ea == 0)) begin
      r.word = {1'b0, {ExpBits{1'b1}}, 1'b1, {(FracBits-1){1'b0}}};
    end else if (ea == 0 || eb == 0) begin
      r.word = {sgn, {(WordBits-1){1'b0}}};
    end else if (&ea || &eb) begin
      r.word = {sgn, {ExpBits{1'b1}}, {FracBits{1'b0}}};
    end else begin
      prod = {{SigBits{1'b0}}, 1'b1, fa} * {{SigBits{1'b0}}, 1'b1, fb};
      e = int'(ea) + int'(eb) - 127;
      if (prod[ProdBits-1]) begin
        frac = prod[2*FracBits:FracBits+1];
        e++;
      end else begin
        frac = prod[2*FracBits-1:FracBits];
      end
      if (e > 254) begin
        r.ovf = 1'b1;
        r.word = {sgn, {ExpBits{1'b1}}, {FracBits{1'b0}}};
      end else if (e < 1) begin
        r.unf = 1'b1;
        r.word = {sgn, {(WordBits-1){1'b0}}};
      end else begin
        r.word = {sgn, e[ExpBits-1:0], frac};
      end
    end
    return r;
  endfunction

  // Build a random factor, mostly normal, sometimes special.
  function automatic logic [WordBits-1:0] random_factor();
    logic [WordBits-1:0] w;
    int pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 5) w[WordBits-2:FracBits] = '0;
    else if (pick < 10) w[WordBits-2:FracBits] = '1;
    else if (pick < 13) w[FracBits-1:0] = '0;
    else if (pick < 60) w[WordBits-2:FracBits] = ExpBits'($urandom_range(64, 190));
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [WordBits-1:0] got,
                                 input logic [WordBits-1:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Driver: advance to the next item on acceptance, idle at random.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (!(in_valid && in_stall)) begin
        if (pending_pairs.size() != 0 && !hold_sender &&
            (calm_stretch || $urandom_range(0, 99) >= 15)) begin
          operand_pair_t p;
          p = pending_pairs.pop_front();
          operand_a <= p.a;
          operand_b <= p.b;
          in_valid  <= 1'b1;
          expected_products.push_back(multiply_truncated(p));
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= calm_stretch ? 1'b0 : ($urandom_range(0, 99) < 15);
    end
  end

  // Monitor: check each accepted product against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_products.size() == 0) begin
        report_mismatch("unexpected product", product, '0);
      end else begin
        product_t want;
        want = expected_products.pop_front();
        if (product !== want.word) report_mismatch("product", product, want.word);
        if (overflow_flag !== want.ovf)
          report_mismatch("overflow_flag", WordBits'(overflow_flag), WordBits'(want.ovf));
        if (underflow_flag !== want.unf)
          report_mismatch("underflow_flag", WordBits'(underflow_flag),
                          WordBits'(want.unf));
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [WordBits-1:0] corner[$];
    operand_pair_t p;
    // Directed corners: zeros, subnormals, infinities, NaNs, extremes.
    corner = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
               32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
               32'h3F80_0000, 32'hBFFF_FFFF, 32'h7F7F_FFFF, 32'h0080_0000};
    foreach (corner[i]) begin
      p.a = corner[i];
      p.b = corner[(i * 5 + 3) % corner.size()];
      pending_pairs.push_back(p);
    end
    // Overflow, underflow and carry into the top significand bit.
    pending_pairs.push_back('{32'h7F00_0000, 32'h4000_0000});
    pending_pairs.push_back('{32'h0080_0000, 32'h3F00_0000});
    pending_pairs.push_back('{32'h3FFF_FFFF, 32'h3FFF_FFFF});
    pending_pairs.push_back('{32'h1F80_0000, 32'h1F80_0000});
    pending_pairs.push_back('{32'h7F7F_FFFF, 32'h3FFF_FFFF});
    pending_pairs.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
    repeat (ItemCount) begin
      p.a = random_factor();
      p.b = random_factor();
      pending_pairs.push_back(p);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Hold the sender once until the pipeline has emptied.
    wait (pending_pairs.size() < ItemCount / 2);
    @(posedge clk);
    hold_sender <= 1'b1;
    wait (expected_products.size() == 0);
    @(posedge clk);
    hold_sender <= 1'b0;
    calm_stretch <= 1'b1;
    wait (pending_pairs.size() < ItemCount / 4);
    @(posedge clk);
    calm_stretch <= 1'b0;

    wait (pending_pairs.size() == 0 && !(in_valid && in_stall));
    wait (expected_products.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/spfm_pkg.sv
sv/spfm_front.sv
sv/spfm_back.sv
sv/single_precision_float_multiply.sv
tb/sv/tb_single_precision_float_multiply.sv
